// ----- src/wpdh_pkg.sv -----
// Shared types and constants of the weighted pair-distance histogram.
// Holds the controller states, datapath command codes and the command/status
// structs; no dependencies.
package wpdh_pkg;

    localparam int COORD_W = 20;
    localparam int DIFF_W  = 21;
    localparam int WGT_W   = 16;
    localparam int WPROD_W = 32;
    localparam int CNT_W   = 32;
    localparam int SUM_W   = 64;
    localparam int RSQ_W   = 43;
    localparam int MUL_W   = 26;
    localparam int PROD_W  = 52;
    localparam int LEN_W   = 20;
    localparam int NBU_W   = 7;
    localparam int BIN_W   = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 20;
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_CNT_W = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIN_WIDTH = 3'd0,
        CFG_BINS_USED = 3'd1,
        CFG_BOX_X     = 3'd2,
        CFG_BOX_Y     = 3'd3,
        CFG_BOX_Z     = 3'd4,
        CFG_FLAT_MODE = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        AX_X = 2'd0,
        AX_Y = 2'd1,
        AX_Z = 2'd2
    } axis_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_FOLD,
        OP_FOLD_FIN,
        OP_SQ,
        OP_ACC,
        OP_CUT_MUL,
        OP_CUT_SQ,
        OP_BIN_INIT,
        OP_BIN_SQ,
        OP_BIN_STEP,
        OP_UPD_RD,
        OP_UPD_WR,
        OP_REP_INIT,
        OP_REP_RD,
        OP_DIV_MEAN,
        OP_OUT_LOAD,
        OP_REP_NEXT,
        OP_CLEAR
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FOLD_GO,
        ST_FOLD_WAIT,
        ST_FOLD_FIN,
        ST_SQ,
        ST_ACC,
        ST_CUT_MUL,
        ST_CUT_SQ,
        ST_CUT_CHK,
        ST_BIN_SQ,
        ST_BIN_CMP,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_LAST_CHK,
        ST_REP_RD,
        ST_REP_DIV,
        ST_REP_WAIT,
        ST_REP_OUT,
        ST_REP_HOLD
    } state_t;

    typedef struct packed {
        dp_op_t op;
        axis_t  axis;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic in_range;
        logic edge_gt;
        logic bin_last;
        logic last_pair;
        logic out_busy;
    } dp_stat_t;

endpackage

// ----- src/weighted_pair_distance_histogram_unit.sv -----
// Weighted pair-distance histogram: top level joining controller and datapath.
// Depends on wpdh_pkg, wpdh_ctrl, wpdh_dp (and wpdh_div below it).
//
// Usage: each input request (in_valid, in_stall) carries one particle pair.
// The difference per axis is folded into the periodic box by minimum image,
// the squared distance is binned against bin_width (pairs at or past the last
// edge are dropped), and the bin's count and weight-product sum are updated in
// a small bin store. A pair with last_pair set is binned first, then every bin
// in use is reported as one output request (out_valid, out_stall) per bin,
// ascending, last_bin on the final one; the store is then cleared.
// Throughput: one pair at a time. A pair runs three 21-step folds on the shared
// divider, then squaring and the cutoff, plus a search step per bin edge passed.
// Each reported bin adds a 64-step mean division and then waits while the
// receiver stalls.
// Stall: the output register holds its bin until taken; no new pair is
// taken while a report is running. Configuration (cfg_valid/cfg_ready,
// always ready) must be written only while idle; the block does not enforce it.
// Reset: state and config registers take defaults and the bin store reads empty
// at once through per-bin valid flags; no clearing pass is needed.
module weighted_pair_distance_histogram_unit #(
    parameter int NBINS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [19:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [19:0]  ref_x,
    input  logic signed [19:0]  ref_y,
    input  logic signed [19:0]  ref_z,
    input  logic signed [15:0]  ref_weight,
    input  logic signed [19:0]  pt_x,
    input  logic signed [19:0]  pt_y,
    input  logic signed [19:0]  pt_z,
    input  logic signed [15:0]  pt_weight,
    input  logic                last_pair,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [5:0]          bin_index,
    output logic [31:0]         pair_count,
    output logic signed [31:0]  mean_weight,
    output logic                last_bin
);
    wpdh_pkg::dp_cmd_t  cmd;
    wpdh_pkg::dp_stat_t stat;

    // configuration writes must come only while idle (not enforced): always take them
    assign cfg_ready = 1'b1;

    wpdh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    wpdh_dp #(
        .NBINS (NBINS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .stat        (stat),
        .ref_x       (ref_x),
        .ref_y       (ref_y),
        .ref_z       (ref_z),
        .ref_weight  (ref_weight),
        .pt_x        (pt_x),
        .pt_y        (pt_y),
        .pt_z        (pt_z),
        .pt_weight   (pt_weight),
        .last_pair   (last_pair),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .bin_index   (bin_index),
        .pair_count  (pair_count),
        .mean_weight (mean_weight),
        .last_bin    (last_bin)
    );

endmodule

// ----- src/wpdh_div.sv -----
// Restoring divider, one quotient bit per cycle, for unsigned 64 / 32.
// Depends on wpdh_pkg for widths.
module wpdh_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [wpdh_pkg::DIV_NUM_W-1:0]       num,
    input  logic [wpdh_pkg::DIV_DEN_W-1:0]       den,
    input  logic [wpdh_pkg::DIV_CNT_W-1:0]       steps,
    output logic                                 done,
    output logic [wpdh_pkg::DIV_NUM_W-1:0]       quo,
    output logic [wpdh_pkg::DIV_DEN_W-1:0]       rem
);
    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [wpdh_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [wpdh_pkg::DIV_NUM_W-1:0]    num_reg, num_next;
    logic [wpdh_pkg::DIV_DEN_W-1:0]    den_reg, den_next;
    logic [wpdh_pkg::DIV_DEN_W-1:0]    rem_reg, rem_next;
    logic [wpdh_pkg::DIV_DEN_W:0]      shifted;
    logic                              ge;

    assign shifted = {rem_reg, num_reg[wpdh_pkg::DIV_NUM_W-1]};
    assign ge      = (shifted >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = steps;
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // shift in one numerator bit, subtract where it fits
            num_next = {num_reg[wpdh_pkg::DIV_NUM_W-2:0], ge};
            rem_next = ge ? wpdh_pkg::DIV_DEN_W'(shifted - {1'b0, den_reg})
                          : shifted[wpdh_pkg::DIV_DEN_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == wpdh_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quo  = num_reg;
    assign rem  = rem_reg;

endmodule

// ----- src/wpdh_dp.sv -----
// Datapath: configuration registers, minimum-image fold, squared distance,
// bin search, bin store and report output register. Uses wpdh_pkg, wpdh_div.
module wpdh_dp #(
    parameter int NBINS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [wpdh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wpdh_pkg::CFG_DAT_W-1:0]     cfg_data,
    input  wpdh_pkg::dp_cmd_t                  cmd,
    output wpdh_pkg::dp_stat_t                 stat,
    input  logic signed [19:0]                 ref_x,
    input  logic signed [19:0]                 ref_y,
    input  logic signed [19:0]                 ref_z,
    input  logic signed [15:0]                 ref_weight,
    input  logic signed [19:0]                 pt_x,
    input  logic signed [19:0]                 pt_y,
    input  logic signed [19:0]                 pt_z,
    input  logic signed [15:0]                 pt_weight,
    input  logic                               last_pair,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [5:0]                         bin_index,
    output logic [31:0]                        pair_count,
    output logic signed [31:0]                 mean_weight,
    output logic                               last_bin
);
    localparam int IW = (NBINS > 1) ? $clog2(NBINS) : 1;
    localparam logic [wpdh_pkg::NBU_W-1:0] NB_MAX = wpdh_pkg::NBU_W'(NBINS);
    localparam int WORD_W = wpdh_pkg::CNT_W + wpdh_pkg::SUM_W;

    // configuration
    logic [19:0] bin_width_reg;
    logic [6:0]  bins_used_reg;
    logic [19:0] box_x_reg, box_y_reg, box_z_reg;
    logic        flat_reg;

    // pair working registers
    logic signed [wpdh_pkg::DIFF_W-1:0]  dx_reg, dy_reg, dz_reg;
    logic signed [wpdh_pkg::DIFF_W-1:0]  fx_reg, fy_reg, fz_reg;
    logic signed [wpdh_pkg::WPROD_W-1:0] wprod_reg;
    logic                                lp_reg;
    logic [wpdh_pkg::PROD_W-1:0]         prod_reg;
    logic [wpdh_pkg::RSQ_W-1:0]          rsq_reg;
    logic [wpdh_pkg::MUL_W-1:0]          edge_reg;
    logic [wpdh_pkg::BIN_W-1:0]          bin_reg;
    logic                                neg_reg;

    // bin store
    logic [WORD_W-1:0] mem [NBINS];
    logic [NBINS-1:0]  vld_reg;
    logic [WORD_W-1:0] rd_word_reg;
    logic              rd_vld_reg;

    // output register
    logic                      out_valid_reg;
    logic [5:0]                out_bin_reg;
    logic [31:0]               out_cnt_reg;
    logic [31:0]               out_mean_reg;
    logic                      out_last_reg;

    logic [wpdh_pkg::NBU_W-1:0]       nb;
    logic [19:0]                      w_eff;
    logic signed [wpdh_pkg::DIFF_W-1:0] d_sel;
    logic signed [wpdh_pkg::DIFF_W-1:0] f_sel;
    logic [19:0]                      len_sel;
    logic [wpdh_pkg::DIFF_W-1:0]      d_abs, f_abs;
    logic [19:0]                      r0;
    logic [20:0]                      r_pos;
    logic signed [21:0]               r_ctr;
    logic signed [wpdh_pkg::DIFF_W-1:0] f_new;
    logic [wpdh_pkg::MUL_W-1:0]       mul_a, mul_b;
    logic [wpdh_pkg::CNT_W-1:0]       cnt_e;
    logic [wpdh_pkg::SUM_W-1:0]       sum_e, sum_abs;
    logic                             mem_we;
    logic [IW-1:0]                    idx;
    logic                             div_start;
    logic [wpdh_pkg::DIV_NUM_W-1:0]   div_num;
    logic [wpdh_pkg::DIV_DEN_W-1:0]   div_den;
    logic [wpdh_pkg::DIV_CNT_W-1:0]   div_steps;
    logic                             div_done;
    logic [wpdh_pkg::DIV_NUM_W-1:0]   div_quo, quo_neg;
    logic [wpdh_pkg::DIV_DEN_W-1:0]   div_rem;
    logic [31:0]                      mean_val;
    logic                             bin_last_w;

    assign nb = (bins_used_reg == '0) ? wpdh_pkg::NBU_W'(1)
              : (bins_used_reg > NB_MAX) ? NB_MAX : bins_used_reg;
    assign w_eff = (bin_width_reg == '0) ? 20'd1 : bin_width_reg;
    assign idx = bin_reg[IW-1:0];
    assign bin_last_w = ({1'b0, bin_reg} + 7'd1) >= nb;

    // axis selection
    always_comb
    begin
        case (cmd.axis)
            wpdh_pkg::AX_Y:
            begin
                d_sel = dy_reg; f_sel = fy_reg; len_sel = box_y_reg;
            end
            wpdh_pkg::AX_Z:
            begin
                d_sel = dz_reg; f_sel = fz_reg; len_sel = box_z_reg;
            end
            default:
            begin
                d_sel = dx_reg; f_sel = fx_reg; len_sel = box_x_reg;
            end
        endcase
    end

    assign d_abs = d_sel[wpdh_pkg::DIFF_W-1] ? wpdh_pkg::DIFF_W'(-d_sel) : d_sel;
    assign f_abs = f_sel[wpdh_pkg::DIFF_W-1] ? wpdh_pkg::DIFF_W'(-f_sel) : f_sel;

    // fold remainder into [-L/2, L/2)
    assign r0 = div_rem[19:0];
    assign r_pos = (d_sel[wpdh_pkg::DIFF_W-1] && (r0 != '0))
                 ? 21'({1'b0, len_sel} - {1'b0, r0}) : {1'b0, r0};
    assign r_ctr = ({r_pos, 1'b0} >= {2'b0, len_sel})
                 ? $signed({1'b0, r_pos}) - $signed({2'b0, len_sel})
                 : $signed({1'b0, r_pos});

    always_comb
    begin
        if (flat_reg && (cmd.axis == wpdh_pkg::AX_Z))
            f_new = '0;
        else if (len_sel == '0)
            f_new = d_sel;
        else
            f_new = r_ctr[wpdh_pkg::DIFF_W-1:0];
    end

    // shared multiplier operands
    always_comb
    begin
        case (cmd.op)
            wpdh_pkg::OP_SQ:
            begin
                mul_a = wpdh_pkg::MUL_W'(f_abs);
                mul_b = wpdh_pkg::MUL_W'(f_abs);
            end
            wpdh_pkg::OP_CUT_MUL:
            begin
                mul_a = wpdh_pkg::MUL_W'(nb);
                mul_b = wpdh_pkg::MUL_W'(w_eff);
            end
            wpdh_pkg::OP_CUT_SQ:
            begin
                mul_a = prod_reg[wpdh_pkg::MUL_W-1:0];
                mul_b = prod_reg[wpdh_pkg::MUL_W-1:0];
            end
            default:
            begin
                mul_a = edge_reg;
                mul_b = edge_reg;
            end
        endcase
    end

    // store word read back, not-yet-written entries read as zero
    assign cnt_e = rd_vld_reg ? rd_word_reg[WORD_W-1:wpdh_pkg::SUM_W] : '0;
    assign sum_e = rd_vld_reg ? rd_word_reg[wpdh_pkg::SUM_W-1:0] : '0;
    assign sum_abs = sum_e[wpdh_pkg::SUM_W-1] ? wpdh_pkg::SUM_W'(-sum_e) : sum_e;
    assign mem_we = (cmd.op == wpdh_pkg::OP_UPD_WR) && (cnt_e != '1);

    // divider requests
    always_comb
    begin
        div_start = 1'b0;
        div_num   = {d_abs, {(wpdh_pkg::DIV_NUM_W-wpdh_pkg::DIFF_W){1'b0}}};
        div_den   = wpdh_pkg::DIV_DEN_W'(len_sel);
        div_steps = wpdh_pkg::DIV_CNT_W'(wpdh_pkg::DIFF_W);
        case (cmd.op)
            wpdh_pkg::OP_DIV_FOLD:
            begin
                div_start = 1'b1;
            end
            wpdh_pkg::OP_DIV_MEAN:
            begin
                div_start = 1'b1;
                div_num   = sum_abs;
                div_den   = cnt_e;
                div_steps = wpdh_pkg::DIV_CNT_W'(wpdh_pkg::DIV_NUM_W);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    wpdh_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .steps (div_steps),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    assign quo_neg  = wpdh_pkg::DIV_NUM_W'(-div_quo);
    assign mean_val = ((bin_reg == '0) || (cnt_e == '0)) ? 32'd0
                    : (neg_reg ? quo_neg[31:0] : div_quo[31:0]);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_width_reg <= 20'd1024;
            bins_used_reg <= 7'd32;
            box_x_reg     <= 20'd65536;
            box_y_reg     <= 20'd65536;
            box_z_reg     <= 20'd65536;
            flat_reg      <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (wpdh_pkg::cfg_idx_t'(cfg_index))
                wpdh_pkg::CFG_BIN_WIDTH: bin_width_reg <= cfg_data;
                wpdh_pkg::CFG_BINS_USED: bins_used_reg <= cfg_data[6:0];
                wpdh_pkg::CFG_BOX_X:     box_x_reg     <= cfg_data;
                wpdh_pkg::CFG_BOX_Y:     box_y_reg     <= cfg_data;
                wpdh_pkg::CFG_BOX_Z:     box_z_reg     <= cfg_data;
                wpdh_pkg::CFG_FLAT_MODE: flat_reg      <= cfg_data[0];
                default:                 flat_reg      <= flat_reg;
            endcase
        end
    end

    // pair payload and arithmetic
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            wpdh_pkg::OP_LOAD:
            begin
                dx_reg    <= wpdh_pkg::DIFF_W'(ref_x) - wpdh_pkg::DIFF_W'(pt_x);
                dy_reg    <= wpdh_pkg::DIFF_W'(ref_y) - wpdh_pkg::DIFF_W'(pt_y);
                dz_reg    <= wpdh_pkg::DIFF_W'(ref_z) - wpdh_pkg::DIFF_W'(pt_z);
                wprod_reg <= ref_weight * pt_weight;
                lp_reg    <= last_pair;
            end
            wpdh_pkg::OP_FOLD_FIN:
            begin
                case (cmd.axis)
                    wpdh_pkg::AX_Y: fy_reg <= f_new;
                    wpdh_pkg::AX_Z: fz_reg <= f_new;
                    default:        fx_reg <= f_new;
                endcase
            end
            wpdh_pkg::OP_SQ, wpdh_pkg::OP_CUT_MUL, wpdh_pkg::OP_CUT_SQ,
            wpdh_pkg::OP_BIN_SQ:
            begin
                prod_reg <= mul_a * mul_b;
            end
            wpdh_pkg::OP_ACC:
            begin
                rsq_reg <= ((cmd.axis == wpdh_pkg::AX_X) ? '0 : rsq_reg)
                         + prod_reg[wpdh_pkg::RSQ_W-1:0];
            end
            wpdh_pkg::OP_BIN_INIT:
            begin
                bin_reg  <= '0;
                edge_reg <= wpdh_pkg::MUL_W'(w_eff);
            end
            wpdh_pkg::OP_BIN_STEP:
            begin
                bin_reg  <= bin_reg + 1'b1;
                edge_reg <= edge_reg + wpdh_pkg::MUL_W'(w_eff);
            end
            wpdh_pkg::OP_REP_INIT:
            begin
                bin_reg <= '0;
            end
            wpdh_pkg::OP_REP_NEXT:
            begin
                bin_reg <= bin_reg + 1'b1;
            end
            wpdh_pkg::OP_DIV_MEAN:
            begin
                neg_reg <= sum_e[wpdh_pkg::SUM_W-1];
            end
            default:
            begin
                neg_reg <= neg_reg;
            end
        endcase
    end

    // bin store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[idx] <= {cnt_e + 1'b1,
                         sum_e + wpdh_pkg::SUM_W'(wprod_reg)};
        if ((cmd.op == wpdh_pkg::OP_UPD_RD) || (cmd.op == wpdh_pkg::OP_REP_RD))
        begin
            rd_word_reg <= mem[idx];
            rd_vld_reg  <= vld_reg[idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (cmd.op == wpdh_pkg::OP_CLEAR)
            vld_reg <= '0;
        else if (mem_we)
            vld_reg[idx] <= 1'b1;
    end

    // report output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == wpdh_pkg::OP_OUT_LOAD)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == wpdh_pkg::OP_OUT_LOAD)
        begin
            out_bin_reg  <= bin_reg;
            out_cnt_reg  <= cnt_e;
            out_mean_reg <= mean_val;
            out_last_reg <= bin_last_w;
        end
    end

    assign out_valid   = out_valid_reg;
    assign bin_index   = out_bin_reg;
    assign pair_count  = out_cnt_reg;
    assign mean_weight = out_mean_reg;
    assign last_bin    = out_last_reg;

    assign stat.div_done  = div_done;
    assign stat.in_range  = {{(wpdh_pkg::PROD_W-wpdh_pkg::RSQ_W){1'b0}}, rsq_reg} < prod_reg;
    assign stat.edge_gt   = prod_reg > {{(wpdh_pkg::PROD_W-wpdh_pkg::RSQ_W){1'b0}}, rsq_reg};
    assign stat.bin_last  = bin_last_w;
    assign stat.last_pair = lp_reg;
    assign stat.out_busy  = out_valid_reg;

endmodule

// ----- src/wpdh_ctrl.sv -----
// Controller state machine: sequences fold, distance, binning and report.
// Depends on wpdh_pkg.
module wpdh_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  wpdh_pkg::dp_stat_t    stat,
    output wpdh_pkg::dp_cmd_t     cmd
);
    wpdh_pkg::state_t state_reg, state_next;
    wpdh_pkg::axis_t  axis_reg, axis_next;
    wpdh_pkg::axis_t  axis_inc;

    always_comb
    begin
        case (axis_reg)
            wpdh_pkg::AX_X: axis_inc = wpdh_pkg::AX_Y;
            wpdh_pkg::AX_Y: axis_inc = wpdh_pkg::AX_Z;
            default:        axis_inc = wpdh_pkg::AX_X;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        case (state_reg)
            wpdh_pkg::ST_IDLE:
                if (in_valid)
                begin
                    state_next = wpdh_pkg::ST_FOLD_GO;
                    axis_next  = wpdh_pkg::AX_X;
                end
            wpdh_pkg::ST_FOLD_GO:   state_next = wpdh_pkg::ST_FOLD_WAIT;
            wpdh_pkg::ST_FOLD_WAIT:
                if (stat.div_done)
                    state_next = wpdh_pkg::ST_FOLD_FIN;
            wpdh_pkg::ST_FOLD_FIN:
            begin
                axis_next  = axis_inc;
                state_next = (axis_reg == wpdh_pkg::AX_Z) ? wpdh_pkg::ST_SQ
                                                          : wpdh_pkg::ST_FOLD_GO;
            end
            wpdh_pkg::ST_SQ:        state_next = wpdh_pkg::ST_ACC;
            wpdh_pkg::ST_ACC:
            begin
                axis_next  = axis_inc;
                state_next = (axis_reg == wpdh_pkg::AX_Z) ? wpdh_pkg::ST_CUT_MUL
                                                          : wpdh_pkg::ST_SQ;
            end
            wpdh_pkg::ST_CUT_MUL:   state_next = wpdh_pkg::ST_CUT_SQ;
            wpdh_pkg::ST_CUT_SQ:    state_next = wpdh_pkg::ST_CUT_CHK;
            wpdh_pkg::ST_CUT_CHK:
                state_next = stat.in_range ? wpdh_pkg::ST_BIN_SQ
                                           : wpdh_pkg::ST_LAST_CHK;
            wpdh_pkg::ST_BIN_SQ:
                state_next = stat.bin_last ? wpdh_pkg::ST_UPD_RD
                                           : wpdh_pkg::ST_BIN_CMP;
            wpdh_pkg::ST_BIN_CMP:
                state_next = stat.edge_gt ? wpdh_pkg::ST_UPD_RD
                                          : wpdh_pkg::ST_BIN_SQ;
            wpdh_pkg::ST_UPD_RD:    state_next = wpdh_pkg::ST_UPD_WR;
            wpdh_pkg::ST_UPD_WR:    state_next = wpdh_pkg::ST_LAST_CHK;
            wpdh_pkg::ST_LAST_CHK:
                state_next = stat.last_pair ? wpdh_pkg::ST_REP_RD
                                            : wpdh_pkg::ST_IDLE;
            wpdh_pkg::ST_REP_RD:    state_next = wpdh_pkg::ST_REP_DIV;
            wpdh_pkg::ST_REP_DIV:   state_next = wpdh_pkg::ST_REP_WAIT;
            wpdh_pkg::ST_REP_WAIT:
                if (stat.div_done)
                    state_next = wpdh_pkg::ST_REP_OUT;
            wpdh_pkg::ST_REP_OUT:   state_next = wpdh_pkg::ST_REP_HOLD;
            wpdh_pkg::ST_REP_HOLD:
                if (!stat.out_busy)
                    state_next = stat.bin_last ? wpdh_pkg::ST_IDLE
                                               : wpdh_pkg::ST_REP_RD;
            default:                state_next = wpdh_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.op   = wpdh_pkg::OP_NONE;
        cmd.axis = axis_reg;
        in_stall = 1'b1;
        case (state_reg)
            wpdh_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                    cmd.op = wpdh_pkg::OP_LOAD;
            end
            wpdh_pkg::ST_FOLD_GO:  cmd.op = wpdh_pkg::OP_DIV_FOLD;
            wpdh_pkg::ST_FOLD_FIN: cmd.op = wpdh_pkg::OP_FOLD_FIN;
            wpdh_pkg::ST_SQ:       cmd.op = wpdh_pkg::OP_SQ;
            wpdh_pkg::ST_ACC:      cmd.op = wpdh_pkg::OP_ACC;
            wpdh_pkg::ST_CUT_MUL:  cmd.op = wpdh_pkg::OP_CUT_MUL;
            wpdh_pkg::ST_CUT_SQ:   cmd.op = wpdh_pkg::OP_CUT_SQ;
            wpdh_pkg::ST_CUT_CHK:  cmd.op = wpdh_pkg::OP_BIN_INIT;
            wpdh_pkg::ST_BIN_SQ:
                if (!stat.bin_last)
                    cmd.op = wpdh_pkg::OP_BIN_SQ;
            wpdh_pkg::ST_BIN_CMP:
                if (!stat.edge_gt)
                    cmd.op = wpdh_pkg::OP_BIN_STEP;
            wpdh_pkg::ST_UPD_RD:   cmd.op = wpdh_pkg::OP_UPD_RD;
            wpdh_pkg::ST_UPD_WR:   cmd.op = wpdh_pkg::OP_UPD_WR;
            wpdh_pkg::ST_LAST_CHK:
                if (stat.last_pair)
                    cmd.op = wpdh_pkg::OP_REP_INIT;
            wpdh_pkg::ST_REP_RD:   cmd.op = wpdh_pkg::OP_REP_RD;
            wpdh_pkg::ST_REP_DIV:  cmd.op = wpdh_pkg::OP_DIV_MEAN;
            wpdh_pkg::ST_REP_OUT:  cmd.op = wpdh_pkg::OP_OUT_LOAD;
            wpdh_pkg::ST_REP_HOLD:
                if (!stat.out_busy)
                    cmd.op = stat.bin_last ? wpdh_pkg::OP_CLEAR
                                           : wpdh_pkg::OP_REP_NEXT;
            default:               cmd.op = wpdh_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wpdh_pkg::ST_IDLE;
            axis_reg  <= wpdh_pkg::AX_X;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

endmodule

// ----- src/wpdh_chk.sv -----
// Port-level checker for the histogram unit, bound to the top level.
// Depends only on the top level's ports.
module wpdh_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [5:0]         bin_index,
    input logic signed [31:0] mean_weight,
    input logic               last_bin
);
    // hold a stalled report
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(bin_index)
                                   && $stable(mean_weight))
        else $error("stalled report changed");

    // no pair is taken while a report is pending
    a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken during report");

    // a freshly taken pair cannot produce a report in the next cycle
    a_in_then_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !out_valid)
        else $error("report too early after pair");

    // report continues until the final bin
    a_report_runs: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_bin |=> in_stall)
        else $error("report ended before final bin");

    // bin zero never carries a mean
    a_bin0_mean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (bin_index == 6'd0) |-> (mean_weight == 32'sd0))
        else $error("bin zero mean not zero");

endmodule

bind weighted_pair_distance_histogram_unit wpdh_chk u_wpdh_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .bin_index   (bin_index),
    .mean_weight (mean_weight),
    .last_bin    (last_bin)
);
